@@ rtl/seven_segment_temperature_driver_unit_assert.svh @@
// Assertion macros for the RTL of the display driver unit, included by ssd_back.
`ifndef SEVEN_SEGMENT_TEMPERATURE_DRIVER_UNIT_ASSERT_SVH
`define SEVEN_SEGMENT_TEMPERATURE_DRIVER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssd assertion failed");

`endif

@@ rtl/ssd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

    // Sizing defaults.
    localparam int DISPLAY_COUNT_DEFAULT = 3;
    localparam int QUEUE_DEPTH_DEFAULT   = 2;

    // Configuration port.
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam int BRIGHT_W = 3;
    localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RESET = 3'd4;
    localparam logic [PADDR_W-1:0]  ADDR_BRIGHTNESS  = 2'd0;

    // Command bytes.
    localparam logic [7:0] CMD_DATA = 8'h40;
    localparam logic [7:0] CMD_ADDR = 8'hC0;
    localparam logic [7:0] CMD_CTRL = 8'h88;

    // Segment patterns for non-digit characters.
    localparam logic [7:0] SEG_NONE = 8'h00;
    localparam logic [7:0] SEG_DASH = 8'h40;
    localparam logic [7:0] SEG_LC   = 8'h39;
    localparam logic [7:0] SEG_LE   = 8'h79;
    localparam logic [7:0] SEG_LR   = 8'h50;

    // Frame lengths.
    localparam logic [2:0] BYTES_NONE = 3'd0;
    localparam logic [2:0] BYTES_CMD  = 3'd1;
    localparam logic [2:0] BYTES_ADDR = 3'd5;

    // Temperature limits in whole degrees.
    localparam logic [12:0] TEMP_MAX_POS = 13'd1023;
    localparam logic [12:0] TEMP_MAX_NEG = 13'd99;

    typedef enum logic [2:0] {
        ACT_INIT      = 3'd0,
        ACT_SHOW_TEMP = 3'd1,
        ACT_SHOW_ERR  = 3'd2,
        ACT_BRIGHT    = 3'd3,
        ACT_DEINIT    = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ARG   = 2'd1,
        ST_NOT_READY = 2'd2
    } status_t;

    // Work classes handed from the front to the back.
    typedef enum logic [1:0] {
        JOB_STATUS = 2'd0,
        JOB_SHOW   = 2'd1,
        JOB_SWEEP  = 2'd2,
        JOB_BRIGHT = 2'd3
    } job_kind_t;

    // Frame within one display update.
    typedef enum logic [1:0] {
        PH_DATA = 2'd0,
        PH_ADDR = 2'd1,
        PH_CTRL = 2'd2
    } phase_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [1:0]         display_sel;
        logic signed [15:0] temperature_sixteenths;
    } cmd_t;

    typedef struct packed {
        logic [1:0] display_index;
        logic [2:0] byte_count;
        logic [7:0] frame_byte0;
        logic [7:0] frame_byte1;
        logic [7:0] frame_byte2;
        logic [7:0] frame_byte3;
        logic [7:0] frame_byte4;
        status_t    status;
        logic       last;
    } frame_t;

    typedef struct packed {
        job_kind_t       kind;
        logic [1:0]      disp;
        logic [3:0][7:0] seg;
        status_t         status;
    } job_t;

    // Segment pattern of a decimal digit.
    function automatic logic [7:0] seg_of_digit(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = SEG_NONE;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/seven_segment_temperature_driver_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// cmd       in         cmd_valid/cmd_stall  cmd_t: action, display_sel, temperature
// frame     out        frame_valid/stall    frame_t: one command frame or status
// apb       in/out     psel/penable/pready  brightness register at address 0
//
// Frames leave the output register back to back while jobs wait and the output
// does not stall; an init, or a deinit of three ready displays, gives nine frames, a show three.
// A command is decoded into front stage one, and its digits are split as it is pushed to the queue.
// The front takes a new command every cycle while the queue has room.
// Reset clears all display ready flags and sets brightness to 4.
// A stalled output holds its frame; the queue lets the front keep working.

module seven_segment_temperature_driver_unit
    import ssd_pkg::*;
#(
    parameter int DISPLAY_COUNT = DISPLAY_COUNT_DEFAULT,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire cmd_t               cmd,
    output logic                    frame_valid,
    input  wire logic               frame_stall,
    output frame_t                  frame,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    localparam int QW = $bits(job_t) + DISPLAY_COUNT;

    logic [BRIGHT_W-1:0]      brightness_reg;
    logic                     bright_wr;
    logic                     job_push;
    job_t                     job;
    logic [DISPLAY_COUNT-1:0] job_mask;
    logic                     queue_full;
    logic                     head_pop;
    logic                     head_valid;
    logic [QW-1:0]            head_data;
    job_t                     head_job;
    logic [DISPLAY_COUNT-1:0] head_mask;

    // Brightness register.
    assign pready    = 1'b1;
    assign bright_wr = psel && penable && pwrite && pready && (paddr == ADDR_BRIGHTNESS);
    assign prdata    = (paddr == ADDR_BRIGHTNESS) ? PDATA_W'(brightness_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= BRIGHTNESS_RESET;
        end
        else if (bright_wr)
        begin
            brightness_reg <= pwdata[BRIGHT_W-1:0];
        end
    end

    // Front: accept and classify.
    ssd_front #(
        .DISPLAY_COUNT (DISPLAY_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .job_push   (job_push),
        .job        (job),
        .job_mask   (job_mask),
        .queue_full (queue_full)
    );

    // Job queue between front and back.
    ssd_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_data  ({job, job_mask}),
        .full       (queue_full),
        .pop        (head_pop),
        .head_data  (head_data),
        .head_valid (head_valid)
    );

    assign head_job  = job_t'(head_data[QW-1:DISPLAY_COUNT]);
    assign head_mask = head_data[DISPLAY_COUNT-1:0];

    // Back: frame generation.
    ssd_back #(
        .DISPLAY_COUNT (DISPLAY_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .brightness  (brightness_reg),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .head_mask   (head_mask),
        .head_pop    (head_pop),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame)
    );

endmodule

`default_nettype wire

@@ rtl/ssd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ssd_front
    import ssd_pkg::*;
#(
    parameter int DISPLAY_COUNT = DISPLAY_COUNT_DEFAULT
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cmd_valid,
    output logic                          cmd_stall,
    input  wire cmd_t                     cmd,
    output logic                          job_push,
    output job_t                          job,
    output logic [DISPLAY_COUNT-1:0]      job_mask,
    input  wire logic                     queue_full
);

    localparam int IW = (DISPLAY_COUNT > 1) ? $clog2(DISPLAY_COUNT) : 1;

    logic                     accept;
    logic [DISPLAY_COUNT-1:0] ready_reg;
    logic [DISPLAY_COUNT-1:0] ready_next;
    logic                     s1_valid_reg;
    logic                     s1_valid_next;

    // Stage one payload.
    job_kind_t                s1_kind_reg;
    logic [1:0]               s1_disp_reg;
    status_t                  s1_status_reg;
    logic [DISPLAY_COUNT-1:0] s1_mask_reg;
    logic                     s1_err_reg;
    logic                     s1_neg_reg;
    logic [9:0]               s1_t_reg;
    logic [6:0]               s1_q1_reg;
    logic [3:0]               s1_q2_reg;

    // Decode results.
    job_kind_t                dec_kind;
    status_t                  dec_status;
    logic [DISPLAY_COUNT-1:0] dec_mask;
    logic                     dec_err;
    logic                     sel_bad;
    logic [IW-1:0]            sel_idx;

    // Rounding and digit split.
    logic                     neg;
    logic [15:0]              mag;
    logic [16:0]              mag_rnd;
    logic [12:0]              t_full;
    logic                     err_t;
    logic [9:0]               t10;
    logic [17:0]              q1_prod;
    logic [15:0]              q2_prod;

    // Item is taken unless stage one is held by a full queue.
    assign cmd_stall = s1_valid_reg && queue_full;
    assign accept    = cmd_valid && !cmd_stall;
    assign job_push  = s1_valid_reg && !queue_full;

    // Round to whole degrees, half away from zero, and split off tens and hundreds.
    always_comb
    begin
        neg     = cmd.temperature_sixteenths[15];
        mag     = neg ? (16'd0 - cmd.temperature_sixteenths) : cmd.temperature_sixteenths;
        mag_rnd = {1'b0, mag} + 17'd8;
        t_full  = mag_rnd[16:4];
        err_t   = neg ? (t_full > TEMP_MAX_NEG) : (t_full > TEMP_MAX_POS);
        t10     = t_full[9:0];
        // Reciprocal multiplies are exact for values up to 1023.
        q1_prod = 18'(t10) * 18'd205;
        q2_prod = 16'(t10) * 16'd41;
    end

    // Classify the command and update the ready flags in command order.
    always_comb
    begin
        sel_bad    = (cmd.display_sel == 2'd0) || (4'(cmd.display_sel) > 4'(DISPLAY_COUNT));
        sel_idx    = IW'(cmd.display_sel - 2'd1);
        ready_next = ready_reg;
        dec_kind   = JOB_STATUS;
        dec_status = ST_BAD_ARG;
        dec_mask   = ready_reg;
        dec_err    = 1'b1;
        unique case (cmd.action)
            ACT_INIT:
            begin
                dec_kind   = JOB_SWEEP;
                dec_status = ST_OK;
                dec_mask   = '1;
                ready_next = '1;
            end
            ACT_SHOW_TEMP, ACT_SHOW_ERR:
            begin
                if (sel_bad)
                begin
                    dec_status = ST_BAD_ARG;
                end
                else if (!ready_reg[sel_idx])
                begin
                    dec_status = ST_NOT_READY;
                end
                else
                begin
                    dec_kind   = JOB_SHOW;
                    dec_status = ST_OK;
                    dec_err    = (cmd.action == ACT_SHOW_ERR) || err_t;
                end
            end
            ACT_BRIGHT:
            begin
                dec_kind   = JOB_BRIGHT;
                dec_status = ST_OK;
            end
            ACT_DEINIT:
            begin
                dec_kind   = (ready_reg == '0) ? JOB_STATUS : JOB_SWEEP;
                dec_status = ST_OK;
                ready_next = '0;
            end
            default:
            begin
                dec_status = ST_BAD_ARG;
            end
        endcase
    end

    // Stage one occupancy.
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (job_push)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            ready_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                ready_reg <= ready_next;
            end
        end
    end

    // Stage one payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg   <= dec_kind;
            s1_disp_reg   <= cmd.display_sel;
            s1_status_reg <= dec_status;
            s1_mask_reg   <= dec_mask;
            s1_err_reg    <= dec_err;
            s1_neg_reg    <= neg;
            s1_t_reg      <= t10;
            s1_q1_reg     <= q1_prod[17:11];
            s1_q2_reg     <= q2_prod[15:12];
        end
    end

    // Stage two: digits and segment bytes.
    logic [9:0] q1_x10;
    logic [9:0] d0_w;
    logic [6:0] q2_x10;
    logic [6:0] d1_w;
    logic [3:0] d0;
    logic [3:0] d1;
    logic [3:0] d2;

    always_comb
    begin
        q1_x10 = 10'(s1_q1_reg) * 10'd10;
        d0_w   = s1_t_reg - q1_x10;
        q2_x10 = 7'(s1_q2_reg) * 7'd10;
        d1_w   = s1_q1_reg - q2_x10;
        d0     = d0_w[3:0];
        d1     = d1_w[3:0];
        d2     = (s1_q2_reg >= 4'd10) ? (s1_q2_reg - 4'd10) : s1_q2_reg;

        job.kind   = s1_kind_reg;
        job.disp   = s1_disp_reg;
        job.status = s1_status_reg;
        job.seg    = {SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE};
        if (s1_kind_reg == JOB_SHOW)
        begin
            if (s1_err_reg)
            begin
                job.seg = {SEG_NONE, SEG_LR, SEG_LR, SEG_LE};
            end
            else
            begin
                job.seg[3] = SEG_LC;
                job.seg[2] = seg_of_digit(d0);
                job.seg[1] = (s1_t_reg >= 10'd10) ? seg_of_digit(d1) : SEG_NONE;
                if (s1_neg_reg && (s1_t_reg != 10'd0))
                begin
                    job.seg[0] = SEG_DASH;
                end
                else
                begin
                    job.seg[0] = (s1_t_reg >= 10'd100) ? seg_of_digit(d2) : SEG_NONE;
                end
            end
        end
        job_mask = s1_mask_reg;
    end

endmodule

`default_nettype wire

@@ rtl/ssd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ssd_queue
    import ssd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT,
    parameter int WIDTH = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head_data,
    output logic                  head_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and occupancy updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ssd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "seven_segment_temperature_driver_unit_assert.svh"

module ssd_back
    import ssd_pkg::*;
#(
    parameter int DISPLAY_COUNT = DISPLAY_COUNT_DEFAULT
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [BRIGHT_W-1:0]      brightness,
    input  wire logic                     head_valid,
    input  wire job_t                     head_job,
    input  wire logic [DISPLAY_COUNT-1:0] head_mask,
    output logic                          head_pop,
    output logic                          frame_valid,
    input  wire logic                     frame_stall,
    output frame_t                        frame
);

    localparam int IW = (DISPLAY_COUNT > 1) ? $clog2(DISPLAY_COUNT) : 1;

    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic [DISPLAY_COUNT-1:0] done_mask_reg;
    logic [DISPLAY_COUNT-1:0] done_mask_next;
    logic [IW-1:0]            idx_reg;
    logic [IW-1:0]            idx_next;
    logic                     out_valid_reg;
    frame_t                   out_reg;

    logic                     emit;
    frame_t                   frm;
    logic [DISPLAY_COUNT-1:0] eff_mask;
    logic [DISPLAY_COUNT-1:0] cur_onehot;
    logic [IW-1:0]            cur;
    logic [IW:0]              cur_disp;
    logic [IW:0]              idx_disp;
    logic [7:0]               ctrl_byte;

    assign emit        = head_valid && (!out_valid_reg || !frame_stall);
    assign frame_valid = out_valid_reg;
    assign frame       = out_reg;
    assign ctrl_byte   = CMD_CTRL | {5'd0, brightness};
    assign eff_mask    = head_mask & ~done_mask_reg;

    // Lowest display still waiting in a sweep.
    always_comb
    begin
        int i;
        cur = '0;
        for (i = DISPLAY_COUNT - 1; i >= 0; i--)
        begin
            if (eff_mask[i])
            begin
                cur = IW'(i);
            end
        end
        cur_onehot = DISPLAY_COUNT'(1) << cur;
        cur_disp   = {1'b0, cur} + (IW + 1)'(1);
        idx_disp   = {1'b0, idx_reg} + (IW + 1)'(1);
    end

    // Frame for the job at the queue head and progress through it.
    always_comb
    begin
        frm            = '0;
        frm.status     = ST_OK;
        phase_next     = phase_reg;
        done_mask_next = done_mask_reg;
        idx_next       = idx_reg;

        unique case (head_job.kind)
            JOB_STATUS:
            begin
                frm.status = head_job.status;
                frm.last   = 1'b1;
            end
            JOB_SHOW, JOB_SWEEP:
            begin
                frm.display_index = (head_job.kind == JOB_SHOW) ? head_job.disp : cur_disp[1:0];
                unique case (phase_reg)
                    PH_DATA:
                    begin
                        frm.byte_count  = BYTES_CMD;
                        frm.frame_byte0 = CMD_DATA;
                        phase_next      = PH_ADDR;
                    end
                    PH_ADDR:
                    begin
                        frm.byte_count  = BYTES_ADDR;
                        frm.frame_byte0 = CMD_ADDR;
                        if (head_job.kind == JOB_SHOW)
                        begin
                            frm.frame_byte1 = head_job.seg[0];
                            frm.frame_byte2 = head_job.seg[1];
                            frm.frame_byte3 = head_job.seg[2];
                            frm.frame_byte4 = head_job.seg[3];
                        end
                        phase_next = PH_CTRL;
                    end
                    PH_CTRL:
                    begin
                        frm.byte_count  = BYTES_CMD;
                        frm.frame_byte0 = ctrl_byte;
                        phase_next      = PH_DATA;
                        done_mask_next  = done_mask_reg | cur_onehot;
                        frm.last        = (head_job.kind == JOB_SHOW)
                                          || ((eff_mask & ~cur_onehot) == '0);
                    end
                    default:
                    begin
                        phase_next = PH_DATA;
                    end
                endcase
            end
            JOB_BRIGHT:
            begin
                if (head_mask[idx_reg])
                begin
                    frm.display_index = idx_disp[1:0];
                    frm.byte_count    = BYTES_CMD;
                    frm.frame_byte0   = ctrl_byte;
                    frm.last          = (idx_reg == IW'(DISPLAY_COUNT - 1));
                end
                else
                begin
                    frm.status = ST_NOT_READY;
                    frm.last   = 1'b1;
                end
                idx_next = idx_reg + IW'(1);
            end
            default:
            begin
                frm.last = 1'b1;
            end
        endcase

        // A finished job leaves the progress counters clear for the next one.
        if (frm.last)
        begin
            phase_next     = PH_DATA;
            done_mask_next = '0;
            idx_next       = '0;
        end
    end

    assign head_pop = emit && frm.last;

    // Progress state advances only when a frame is emitted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DATA;
            done_mask_reg <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                phase_reg     <= phase_next;
                done_mask_reg <= done_mask_next;
                idx_reg       <= idx_next;
                out_valid_reg <= 1'b1;
            end
            else if (!frame_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= frm;
        end
    end

    // A sweep at the queue head always has a display left to update.
    `SSD_ASSERT_IMP(a_sweep_has_work, clk, rst_n, head_valid && head_job.kind == JOB_SWEEP, eff_mask != '0)
    // Ending a job clears all progress state.
    `SSD_ASSERT_NEXT(a_progress_clears, clk, rst_n, emit && frm.last, phase_reg == PH_DATA && done_mask_reg == '0 && idx_reg == '0)
    // An error status is always a lone status-only frame.
    `SSD_ASSERT_IMP(a_status_alone, clk, rst_n, frame_valid && frame.status != ST_OK, frame.last && frame.byte_count == BYTES_NONE && frame.display_index == 2'd0)
    // Mid-update phases of a show job never pop the queue.
    `SSD_ASSERT_IMP(a_no_early_pop, clk, rst_n, head_pop && (head_job.kind == JOB_SHOW), phase_reg == PH_CTRL)

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import ssd_pkg::*;

    localparam int DISPLAYS         = 3;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int DRAIN_CYCLES     = 16;
    localparam int HOLD_CYCLES      = 300;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_ITEMS      = 52;
    localparam int PRESSURE_ITEMS   = 24;

    // Action codes that the block does not define.
    localparam logic [2:0] ACT_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] ACT_UNDEF_LAST  = 3'd7;
    localparam logic [1:0] SEL_NONE        = 2'd0;

    localparam logic [31:0] BLANK_SEGS = {SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE};
    localparam logic [31:0] ERR_SEGS   = {SEG_LE, SEG_LR, SEG_LR, SEG_NONE};

    // Temperatures in sixteenths that sit on rounding and range boundaries.
    localparam int EDGE_COUNT = 14;
    localparam logic [EDGE_COUNT-1:0][15:0] EDGE_TEMPS = {
        16'sd0, 16'sd7, 16'sd8, -16'sd7, -16'sd8, 16'sd159, 16'sd1592, 16'sd16000,
        16'sd16375, 16'sd16376, -16'sd1591, -16'sd1592, 16'h7FFF, 16'h8000
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_stall;
    cmd_t                 cmd = '0;
    logic                 frame_valid;
    logic                 frame_stall = 1'b0;
    frame_t               frame;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Traffic shaping shared by the sender and the frame sink.
    bit                   idle_on = 1'b1;
    logic                 sink_hold = 1'b0;

    // Predicted display state and the frames still owed by the block.
    bit                   ready_flag [1:DISPLAYS];
    logic [BRIGHT_W-1:0]  bright_level = BRIGHTNESS_RESET;
    frame_t               expected_frames [$];
    frame_t               held_frame;
    bit                   frame_held;

    int                   mismatch_count = 0;
    int                   frames_checked = 0;
    int                   brightness_settings = 0;
    int                   longest_cmd_wait = 0;
    int                   action_count [0:7];

    seven_segment_temperature_driver_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Print one mismatch line and count it.
    task automatic report_error(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_error($sformatf("frame %0d %s: got %h, want %h",
                                   frames_checked, name, got, want));
    endtask

    function automatic logic [7:0] digit_pattern(int d);
        case (d)
            0: return 8'h3F;
            1: return 8'h06;
            2: return 8'h5B;
            3: return 8'h4F;
            4: return 8'h66;
            5: return 8'h6D;
            6: return 8'h7D;
            7: return 8'h07;
            8: return 8'h7F;
            9: return 8'h6F;
            default: return SEG_NONE;
        endcase
    endfunction

    // Round to whole degrees, half away from zero, and lay out the four digits.
    function automatic logic [31:0] temp_segments(logic [15:0] raw);
        bit          neg;
        int          mag;
        int          deg;
        logic [31:0] s;
        neg = raw[15];
        mag = neg ? (32'h10000 - int'({16'd0, raw})) : int'({16'd0, raw});
        deg = (mag + 8) >> 4;
        s = ERR_SEGS;
        if (!(neg ? deg > 99 : deg > 1023))
        begin
            s = {SEG_NONE, SEG_NONE, SEG_NONE, SEG_LC};
            if (neg && deg != 0)
            begin
                s[31:24] = SEG_DASH;
                if (deg >= 10)
                    s[23:16] = digit_pattern(deg / 10);
                s[15:8] = digit_pattern(deg % 10);
            end
            else if (deg >= 100)
            begin
                // The thousands digit of 1000 to 1023 is dropped.
                s[31:24] = digit_pattern((deg / 100) % 10);
                s[23:16] = digit_pattern((deg / 10) % 10);
                s[15:8]  = digit_pattern(deg % 10);
            end
            else if (deg >= 10)
            begin
                s[23:16] = digit_pattern(deg / 10);
                s[15:8]  = digit_pattern(deg % 10);
            end
            else
            begin
                s[15:8] = digit_pattern(deg);
            end
        end
        return s;
    endfunction

    // Frames are held back by one so that the final one can be marked last.
    function automatic void stage_frame(logic [1:0] disp, logic [2:0] cnt, logic [7:0] b0,
                                        logic [31:0] segs, status_t st);
        frame_t f;
        if (frame_held)
            expected_frames.push_back(held_frame);
        f.display_index = disp;
        f.byte_count    = cnt;
        f.frame_byte0   = b0;
        f.frame_byte1   = segs[31:24];
        f.frame_byte2   = segs[23:16];
        f.frame_byte3   = segs[15:8];
        f.frame_byte4   = segs[7:0];
        f.status        = st;
        f.last          = 1'b0;
        held_frame = f;
        frame_held = 1'b1;
    endfunction

    function automatic void stage_ctrl(logic [1:0] disp);
        stage_frame(disp, BYTES_CMD, CMD_CTRL | {5'd0, bright_level}, BLANK_SEGS, ST_OK);
    endfunction

    function automatic void stage_update(logic [1:0] disp, logic [31:0] segs);
        stage_frame(disp, BYTES_CMD, CMD_DATA, BLANK_SEGS, ST_OK);
        stage_frame(disp, BYTES_ADDR, CMD_ADDR, segs, ST_OK);
        stage_ctrl(disp);
    endfunction

    function automatic void stage_status(status_t st);
        stage_frame(2'd0, BYTES_NONE, 8'h00, BLANK_SEGS, st);
    endfunction

    // Work out every frame that one accepted command causes.
    function automatic void predict_frames(cmd_t c);
        bit any_ready;
        bit stopped;
        frame_held = 1'b0;
        action_count[c.action]++;
        case (c.action)
            ACT_INIT:
            begin
                for (int i = 1; i <= DISPLAYS; i++)
                begin
                    ready_flag[i] = 1'b1;
                    stage_update(2'(i), BLANK_SEGS);
                end
            end
            ACT_SHOW_TEMP, ACT_SHOW_ERR:
            begin
                if (c.display_sel == SEL_NONE || int'(c.display_sel) > DISPLAYS)
                    stage_status(ST_BAD_ARG);
                else if (!ready_flag[c.display_sel])
                    stage_status(ST_NOT_READY);
                else if (c.action == ACT_SHOW_TEMP)
                    stage_update(c.display_sel, temp_segments(c.temperature_sixteenths));
                else
                    stage_update(c.display_sel, ERR_SEGS);
            end
            ACT_BRIGHT:
            begin
                // Stop at the first display that is not ready.
                stopped = 1'b0;
                for (int i = 1; i <= DISPLAYS; i++)
                begin
                    if (!stopped)
                    begin
                        if (!ready_flag[i])
                        begin
                            stage_status(ST_NOT_READY);
                            stopped = 1'b1;
                        end
                        else
                        begin
                            stage_ctrl(2'(i));
                        end
                    end
                end
            end
            ACT_DEINIT:
            begin
                any_ready = 1'b0;
                for (int i = 1; i <= DISPLAYS; i++)
                begin
                    if (ready_flag[i])
                    begin
                        stage_update(2'(i), BLANK_SEGS);
                        ready_flag[i] = 1'b0;
                        any_ready = 1'b1;
                    end
                end
                if (!any_ready)
                    stage_status(ST_OK);
            end
            default:
            begin
                stage_status(ST_BAD_ARG);
            end
        endcase
        held_frame.last = 1'b1;
        expected_frames.push_back(held_frame);
        frame_held = 1'b0;
    endfunction

    task automatic check_frame(input frame_t got);
        frame_t want;
        frames_checked++;
        if (expected_frames.size() == 0)
        begin
            report_error($sformatf("frame %0d arrived with nothing expected: %h",
                                   frames_checked, got));
            return;
        end
        want = expected_frames.pop_front();
        compare_field("display_index", 8'(got.display_index), 8'(want.display_index));
        compare_field("byte_count", 8'(got.byte_count), 8'(want.byte_count));
        compare_field("frame_byte0", got.frame_byte0, want.frame_byte0);
        compare_field("frame_byte1", got.frame_byte1, want.frame_byte1);
        compare_field("frame_byte2", got.frame_byte2, want.frame_byte2);
        compare_field("frame_byte3", got.frame_byte3, want.frame_byte3);
        compare_field("frame_byte4", got.frame_byte4, want.frame_byte4);
        compare_field("status", 8'(got.status), 8'(want.status));
        compare_field("last", 8'(got.last), 8'(want.last));
    endtask

    function automatic cmd_t make_cmd(logic [2:0] act, logic [1:0] sel, logic [15:0] temp);
        cmd_t c;
        c.action                 = act;
        c.display_sel            = sel;
        c.temperature_sixteenths = temp;
        return c;
    endfunction

    function automatic logic [15:0] random_temp();
        int v;
        case ($urandom_range(0, 3))
            0:       v = $urandom_range(0, 65535);
            1:       v = int'($urandom_range(0, 18000)) - 1600;
            2:       v = int'($urandom_range(0, 400)) - 200;
            default: v = int'(EDGE_TEMPS[$urandom_range(0, EDGE_COUNT - 1)])
                         + int'($urandom_range(0, 4)) - 2;
        endcase
        return v[15:0];
    endfunction

    // Mostly display updates on real displays, with occasional noise.
    function automatic cmd_t random_cmd();
        cmd_t c;
        int   pick;
        pick = $urandom_range(0, 99);
        c.display_sel = 2'($urandom_range(0, 3));
        c.temperature_sixteenths = random_temp();
        if (pick < 6)
            c.action = ACT_INIT;
        else if (pick < 62)
            c.action = ACT_SHOW_TEMP;
        else if (pick < 74)
            c.action = ACT_SHOW_ERR;
        else if (pick < 86)
            c.action = ACT_BRIGHT;
        else if (pick < 89)
            c.action = ACT_DEINIT;
        else if (pick < 94)
            c.action = 3'($urandom_range(ACT_UNDEF_FIRST, ACT_UNDEF_LAST));
        else
            c.action = ACT_SHOW_TEMP;
        // Show commands mostly target a real display.
        if (pick < 94 && (c.action == ACT_SHOW_TEMP || c.action == ACT_SHOW_ERR))
            c.display_sel = 2'($urandom_range(1, DISPLAYS));
        else if (pick >= 94)
            c.display_sel = SEL_NONE;
        return c;
    endfunction

    // Offer one item, after a random gap while idle_on is set, and wait until it is taken.
    task automatic send_cmd(input cmd_t c);
        int gap;
        int waited;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        waited = 0;
        @(posedge clk);
        while (cmd_stall)
        begin
            waited++;
            @(posedge clk);
        end
        if (waited > longest_cmd_wait)
            longest_cmd_wait = waited;
        predict_frames(c);
    endtask

    // Stop offering and wait until every owed frame has come out.
    task automatic drain();
        cmd_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the brightness register, then read it back in the next transfer.
    task automatic set_brightness(input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BRIGHTNESS;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        bright_level = value[BRIGHT_W-1:0];
        brightness_settings++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== PDATA_W'(bright_level))
            report_error($sformatf("brightness read back %h, want %h", prdata, bright_level));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Commands on displays that were never initialized, bad selectors, bad actions.
    task automatic test_before_init();
        send_cmd(make_cmd(ACT_SHOW_TEMP, 2'd1, 16'sd400));
        send_cmd(make_cmd(ACT_SHOW_ERR, 2'd3, 16'h0000));
        send_cmd(make_cmd(ACT_SHOW_TEMP, SEL_NONE, 16'hFFFF));
        send_cmd(make_cmd(ACT_BRIGHT, 2'd2, 16'h5555));
        send_cmd(make_cmd(ACT_DEINIT, 2'd1, 16'hAAAA));
        send_cmd(make_cmd(ACT_UNDEF_FIRST, 2'd3, 16'h0000));
        send_cmd(make_cmd(ACT_UNDEF_LAST, SEL_NONE, 16'hFFFF));
        drain();
    endtask

    // Rounding and range limits of the temperature layout on every display.
    task automatic test_temperature_format();
        send_cmd(make_cmd(ACT_INIT, SEL_NONE, 16'h0000));
        for (int k = 0; k < EDGE_COUNT; k++)
            send_cmd(make_cmd(ACT_SHOW_TEMP, 2'(k % DISPLAYS + 1), EDGE_TEMPS[k]));
        send_cmd(make_cmd(ACT_SHOW_ERR, 2'd2, 16'h1234));
        send_cmd(make_cmd(ACT_SHOW_ERR, SEL_NONE, 16'h1234));
        send_cmd(make_cmd(ACT_DEINIT, 2'd3, 16'h0000));
        send_cmd(make_cmd(ACT_DEINIT, 2'd3, 16'h0000));
        drain();
    endtask

    // Both brightness extremes reach the control frames.
    task automatic test_brightness_register();
        set_brightness(32'd0);
        send_cmd(make_cmd(ACT_INIT, 2'd1, 16'h0000));
        send_cmd(make_cmd(ACT_BRIGHT, 2'd1, 16'h0000));
        drain();
        set_brightness(32'd7);
        send_cmd(make_cmd(ACT_BRIGHT, 2'd2, 16'h0000));
        send_cmd(make_cmd(ACT_DEINIT, 2'd2, 16'h0000));
        drain();
    endtask

    // Random commands in phases, each with its own brightness.
    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idle_on <= (phase % 3) != 2;
            if (phase == 0)
                set_brightness(32'd7);
            else if (phase == 1)
                set_brightness(32'd0);
            else if (phase == RANDOM_PHASES - 1)
                set_brightness(32'(BRIGHTNESS_RESET));
            else
                set_brightness($urandom());
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_cmd(random_cmd());
            drain();
        end
    endtask

    // The sink holds off for a long stretch while commands keep coming.
    task automatic test_output_backpressure();
        idle_on <= 1'b0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold <= 1'b0;
            end
        join_none
        send_cmd(make_cmd(ACT_INIT, 2'd2, 16'h0000));
        for (int k = 0; k < PRESSURE_ITEMS; k++)
            send_cmd(random_cmd());
        drain();
        idle_on <= 1'b1;
    endtask

    // Frame sink: take frames with random stalls and check each one.
    initial
    begin : frame_sink
        int stall_left;
        bit took;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            took = rst_n && frame_valid && !frame_stall;
            if (took)
            begin
                check_frame(frame);
                stall_left = idle_on ? $urandom_range(0, 4) : 0;
            end
            frame_stall <= sink_hold || (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // End the run when no handshake of any kind has happened for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (frame_valid && !frame_stall) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no handshake for %0d cycles", quiet);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : main_sequence
        for (int i = 1; i <= DISPLAYS; i++)
            ready_flag[i] = 1'b0;
        for (int i = 0; i < 8; i++)
            action_count[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_init();
        test_temperature_format();
        test_brightness_register();
        test_random_traffic();
        test_output_backpressure();

        $display("covered: %0d init, %0d show temperature, %0d show error, %0d brightness,",
                 action_count[ACT_INIT], action_count[ACT_SHOW_TEMP],
                 action_count[ACT_SHOW_ERR], action_count[ACT_BRIGHT]);
        $display("  %0d deinit, %0d undefined; %0d frames over %0d settings, input held %0d cycles",
                 action_count[ACT_DEINIT],
                 action_count[5] + action_count[6] + action_count[7],
                 frames_checked, brightness_settings, longest_cmd_wait);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ seven_segment_temperature_driver_unit.f @@
+incdir+rtl
rtl/ssd_pkg.sv
rtl/ssd_front.sv
rtl/ssd_queue.sv
rtl/ssd_back.sv
rtl/seven_segment_temperature_driver_unit.sv
tb/tb_top.sv
